[rtl/cmr_pkg.sv]
// ----------------------------------------------------------------------------
// cmr_pkg
// Shared types and constants for the multiplexed challenge reassembly block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmr_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned ADDR_W    = 8;
  localparam int unsigned NIB_W     = 4;
  localparam int unsigned CNT_W     = 14;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 14;
  localparam int unsigned APPEND_W  = 56;
  localparam int unsigned NUM_W     = 3;

  localparam logic [ADDR_W-1:0] BCAST_ADDR  = 8'hFF;
  localparam logic [CNT_W-1:0]  TIMEOUT_RST = 14'd10000;
  localparam logic [CNT_W-1:0]  COUNT_MAX   = 14'h3FFF;
  localparam logic [NUM_W-1:0]  START_BYTES = 3'd5;
  localparam logic [NUM_W-1:0]  MID_BYTES   = 3'd7;

  typedef enum logic [OP_W-1:0] {
    OP_FRAME = 2'd0,
    OP_TICK  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } cmr_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEVICE_ADDRESS = 2'd0,
    REG_CHALLENGE_TYPE = 2'd1,
    REG_TIMEOUT_MS     = 2'd2,
    REG_UNUSED         = 2'd3
  } cmr_reg_e;

  // append request: data byte k goes to store index base + k for k < count
  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    base;
    logic [NUM_W-1:0]    count;
    logic [APPEND_W-1:0] data;
  } cmr_wr_t;

  // read request, load is high for every accepted item
  typedef struct packed {
    logic             load;
    logic             rd;
    logic [IDX_W-1:0] index;
  } cmr_rd_t;

endpackage

`default_nettype wire

[rtl/cmr_if.sv]
// ----------------------------------------------------------------------------
// cmr_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cmr_in_if import cmr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [PAYLOAD_W-1:0] frame_payload;
  logic [IDX_W-1:0]     read_index;

  modport source (output valid, output opcode, output frame_payload, output read_index,
                  input ready);
  modport sink   (input valid, input opcode, input frame_payload, input read_index,
                  output ready);
endinterface

interface cmr_out_if import cmr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              frame_taken;
  logic              challenge_done;
  logic              gate_closed;
  logic [ADDR_W-1:0] session_target;
  logic [NIB_W-1:0]  session_request_id;
  logic [NIB_W-1:0]  session_step;
  logic [IDX_W-1:0]  fill_count;
  logic [ADDR_W-1:0] read_byte;

  modport source (output valid, output frame_taken, output challenge_done,
                  output gate_closed, output session_target, output session_request_id,
                  output session_step, output fill_count, output read_byte,
                  input ready);
  modport sink   (input valid, input frame_taken, input challenge_done,
                  input gate_closed, input session_target, input session_request_id,
                  input session_step, input fill_count, input read_byte,
                  output ready);
endinterface

`default_nettype wire

[rtl/cmr_store.sv]
// ----------------------------------------------------------------------------
// cmr_store
// Challenge byte store: two banks of 8-byte rows so an append that spans two
// rows writes one row in each bank, per-byte valid bits, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmr_store import cmr_pkg::*; #(
  parameter int unsigned CHALLENGE_BYTES = 47
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmr_wr_t           wr_i,
  input  wire cmr_rd_t           rd_i,
  output logic [ADDR_W-1:0]      read_byte_o
);

  localparam int unsigned ROWS  = (CHALLENGE_BYTES + 7) / 8;
  localparam int unsigned EROWS = (ROWS + 1) / 2;
  localparam int unsigned OROWS = (ROWS / 2 > 0) ? ROWS / 2 : 1;
  localparam int unsigned EW    = (EROWS > 1) ? $clog2(EROWS) : 1;
  localparam int unsigned OW    = (OROWS > 1) ? $clog2(OROWS) : 1;
  localparam logic [IDX_W:0] CAP = (IDX_W + 1)'(CHALLENGE_BYTES);

  logic [63:0] bank_e [EROWS];
  logic [63:0] bank_o [OROWS];
  logic [CHALLENGE_BYTES-1:0] vld_q;

  logic [127:0] win;
  logic [15:0]  win_be;
  logic [2:0]   row0;
  logic [3:0]   row1;
  logic [1:0]   e_row;
  logic [1:0]   o_row;
  logic [63:0]  e_data;
  logic [63:0]  o_data;
  logic [7:0]   e_be;
  logic [7:0]   o_be;

  logic [63:0] rd_e_q;
  logic [63:0] rd_o_q;
  logic        sel_bank_q;
  logic [2:0]  sel_byte_q;
  logic        hit_q;
  logic        hit;
  logic [63:0] rd_row;

  always_comb begin
    win    = 128'({8'h00, wr_i.data}) << {wr_i.base[2:0], 3'b000};
    win_be = 16'((16'd1 << wr_i.count) - 16'd1) << wr_i.base[2:0];
    if (!wr_i.en) begin
      win_be = '0;
    end
    row0 = wr_i.base[5:3];
    row1 = {1'b0, row0} + 4'd1;
    if (!row0[0]) begin
      e_row  = row0[2:1];
      e_data = win[63:0];
      e_be   = win_be[7:0];
      o_row  = row0[2:1];
      o_data = win[127:64];
      o_be   = win_be[15:8];
    end else begin
      e_row  = row1[2:1];
      e_data = win[127:64];
      e_be   = win_be[15:8];
      o_row  = row0[2:1];
      o_data = win[63:0];
      o_be   = win_be[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 8; b++) begin
      if (e_be[b]) begin
        bank_e[e_row[EW-1:0]][b*8 +: 8] <= e_data[b*8 +: 8];
      end
      if (o_be[b]) begin
        bank_o[o_row[OW-1:0]][b*8 +: 8] <= o_data[b*8 +: 8];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      for (int i = 0; i < CHALLENGE_BYTES; i++) begin
        if ((IDX_W + 1)'(i) >= {1'b0, wr_i.base} &&
            (IDX_W + 1)'(i) < {1'b0, wr_i.base} + (IDX_W + 1)'(wr_i.count)) begin
          vld_q[i] <= 1'b1;
        end
      end
    end
  end

  // bytes never written read as zero
  assign hit = rd_i.rd && ({1'b0, rd_i.index} < CAP) && vld_q[rd_i.index];

  always_ff @(posedge clk_i) begin
    if (rd_i.load && rd_i.rd) begin
      rd_e_q     <= bank_e[rd_i.index[5:4]];
      rd_o_q     <= bank_o[rd_i.index[5:4]];
      sel_bank_q <= rd_i.index[3];
      sel_byte_q <= rd_i.index[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (rd_i.load) begin
      hit_q <= hit;
    end
  end

  assign rd_row      = sel_bank_q ? rd_o_q : rd_e_q;
  assign read_byte_o = hit_q ? rd_row[{sel_byte_q, 3'b000} +: 8] : '0;

endmodule

`default_nettype wire

[rtl/multiplexed_challenge_reassembly.sv]
// ----------------------------------------------------------------------------
// multiplexed_challenge_reassembly
// Session gate and challenge reassembly over multiplexed CAN frames.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        contents
//  in_ch     in   valid/ready      opcode, frame_payload, read_index
//  out_ch    out  valid/ready      status, fill count, read byte
//  cfg       in   cfg_we_i         device address, challenge type, timeout
//
//  one item accepted every cycle while in_ch.ready is high; the result sits in the
//  output register the cycle after acceptance
//  in_ch.ready is low only while a result waits and out_ch.ready is low
//  reset restores session state and config and clears store valid bits; no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multiplexed_challenge_reassembly import cmr_pkg::*; #(
  parameter int unsigned CHALLENGE_BYTES = 47
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  cmr_in_if.sink                    in_ch,
  cmr_out_if.source                 out_ch,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam logic [IDX_W-1:0] CAP = IDX_W'(CHALLENGE_BYTES);

  logic [ADDR_W-1:0] dev_addr_q;
  logic [NIB_W-1:0]  chal_code_q;
  logic [CNT_W-1:0]  timeout_q;

  logic              gate_open_q, gate_open_d;
  logic [CNT_W-1:0]  since_q, since_d;
  logic [ADDR_W-1:0] tgt_q, tgt_d;
  logic [NIB_W-1:0]  rid_q, rid_d;
  logic [NIB_W-1:0]  step_q, step_d;
  logic [NIB_W-1:0]  last_q, last_d;
  logic [IDX_W-1:0]  fill_q, fill_d;
  logic              taken_q, taken_d;
  logic              done_q, done_d;
  logic              out_valid_q;

  logic              accept;
  cmr_op_e           op;
  logic [7:0]        b0, b1, b2;
  logic [NIB_W-1:0]  mux, rtype;
  logic              is_start, match;
  logic [IDX_W-1:0]  space;
  logic [NUM_W-1:0]  avail;
  logic [IDX_W-1:0]  fill_new;
  cmr_wr_t           wr;
  cmr_rd_t           rd;

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign op          = cmr_op_e'(in_ch.opcode);

  assign b0       = in_ch.frame_payload[7:0];
  assign b1       = in_ch.frame_payload[15:8];
  assign b2       = in_ch.frame_payload[23:16];
  assign mux      = b0[3:0];
  assign rtype    = b0[7:4];
  assign is_start = (mux == '0);
  assign match    = (b2 == dev_addr_q) || (b2 == BCAST_ADDR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= '0;
      chal_code_q <= '0;
      timeout_q   <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cmr_reg_e'(cfg_idx_i))
        REG_DEVICE_ADDRESS: dev_addr_q  <= cfg_data_i[ADDR_W-1:0];
        REG_CHALLENGE_TYPE: chal_code_q <= cfg_data_i[NIB_W-1:0];
        REG_TIMEOUT_MS:     timeout_q   <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    gate_open_d = gate_open_q;
    since_d     = since_q;
    tgt_d       = tgt_q;
    rid_d       = rid_q;
    step_d      = step_q;
    last_d      = last_q;
    fill_d      = fill_q;
    taken_d     = 1'b0;
    done_d      = 1'b0;
    wr          = '0;
    avail       = is_start ? START_BYTES : MID_BYTES;
    space       = '0;
    fill_new    = '0;
    case (op)
      OP_TICK: begin
        if (since_q != COUNT_MAX) begin
          since_d = since_q + CNT_W'(1);
        end
      end
      OP_FRAME: begin
        if (gate_open_q || since_q >= timeout_q) begin
          gate_open_d = 1'b1;
          taken_d     = 1'b1;
          since_d     = '0;
          if (is_start && match) begin
            tgt_d  = b2;
            rid_d  = b1[3:0];
            last_d = b1[7:4];
            step_d = rtype;
            fill_d = '0;
            if (rtype != chal_code_q) begin
              gate_open_d = 1'b0;
            end
          end
          if ((!is_start || match) && rtype == chal_code_q) begin
            space = CAP - fill_d;
            wr.en    = (fill_d < CAP);
            wr.base  = fill_d;
            wr.count = (space < IDX_W'(avail)) ? space[NUM_W-1:0] : avail;
            wr.data  = is_start ? APPEND_W'(in_ch.frame_payload[63:24])
                                : in_ch.frame_payload[63:8];
            fill_new = wr.en ? fill_d + IDX_W'(wr.count) : fill_d;
            fill_d   = fill_new;
            if (fill_new >= CAP || last_d <= mux) begin
              done_d      = 1'b1;
              gate_open_d = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign rd.load  = accept;
  assign rd.rd    = (op == OP_READ);
  assign rd.index = in_ch.read_index;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_open_q <= 1'b1;
      since_q     <= '0;
      tgt_q       <= '0;
      rid_q       <= '0;
      step_q      <= '0;
      last_q      <= '0;
      fill_q      <= '0;
      taken_q     <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        gate_open_q <= gate_open_d;
        since_q     <= since_d;
        tgt_q       <= tgt_d;
        rid_q       <= rid_d;
        step_q      <= step_d;
        last_q      <= last_d;
        fill_q      <= fill_d;
        taken_q     <= taken_d;
        done_q      <= done_d;
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  cmr_store #(
    .CHALLENGE_BYTES(CHALLENGE_BYTES)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (accept ? wr : '0),
    .rd_i       (rd),
    .read_byte_o(out_ch.read_byte)
  );

  // session state only moves on an accepted item, so it doubles as the result
  assign out_ch.valid              = out_valid_q;
  assign out_ch.frame_taken        = taken_q;
  assign out_ch.challenge_done     = done_q;
  assign out_ch.gate_closed        = !gate_open_q;
  assign out_ch.session_target     = tgt_q;
  assign out_ch.session_request_id = rid_q;
  assign out_ch.session_step       = step_q;
  assign out_ch.fill_count         = fill_q;

endmodule

`default_nettype wire
